>>> rtl/tskv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tskv_pkg
// Shared types and constants of the two-sector log key-value store.
// ----------------------------------------------------------------------------
package tskv_pkg;

	localparam logic [1:0] CMD_MOUNT = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_NONE  = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	localparam logic [15:0] FLAG_MARK   = 16'h55aa;
	localparam logic [31:0] ERASED      = 32'hffff_ffff;
	localparam logic [15:0] LIMIT_RESET = 16'd10000;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] key_index;
		logic [31:0] value;
		logic [31:0] fallback;
		logic        key_bad;
	} item_t;

endpackage

>>> rtl/two_sector_log_kv_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sector_log_kv_store_top
// Key-value store kept as an append-only log in two sectors of one memory.
// ----------------------------------------------------------------------------
// channel   handshake             payload
// input     in_valid / in_stall   command, key_index, value, fallback
// output    out_valid / out_stall read_value, status
// config    index_limit_we        index_limit_wdata
//
// One command at a time through a sequencer with one read and one write port.
// Mount, range errors and early misses answer straight from the queue; a
// write appends a flag word and a value word; a read searches entries backward
// from the newest; a compaction copies the newest entry of every key up to the
// highest key into the other sector, then appends, one memory read at a time.
// A two-entry queue keeps taking commands while the sequencer works, until both entries are full.
// Reset clears pointers and control registers, not the memory; words at and
// past the write pointer are never read, so the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module two_sector_log_kv_store_top #(
	parameter int SECTOR_WORDS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] key_index,
	input  logic [31:0] value,
	input  logic [31:0] fallback,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic [1:0]  status,
	input  logic        index_limit_we,
	input  logic [15:0] index_limit_wdata
);

	logic            item_valid;
	logic            item_pop;
	tskv_pkg::item_t item;

	tskv_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.key_index         (key_index),
		.value             (value),
		.fallback          (fallback),
		.index_limit_we    (index_limit_we),
		.index_limit_wdata (index_limit_wdata),
		.item_valid        (item_valid),
		.item_pop          (item_pop),
		.item              (item)
	);

	tskv_back #(
		.SECTOR_WORDS (SECTOR_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status)
	);

	// a new command only starts once the previous result is gone
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid && !out_valid)
		else $error("command taken while result pending");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tskv_pkg::STAT_FULL |-> read_value == 32'd0)
		else $error("sector full result carries data");

	a_pop_once: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> !item_pop)
		else $error("two commands started back to back");

endmodule

>>> rtl/tskv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tskv_front
// Takes commands, checks the key against the limit register, queues them.
// ----------------------------------------------------------------------------
module tskv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [15:0]       key_index,
	input  logic [31:0]       value,
	input  logic [31:0]       fallback,
	input  logic              index_limit_we,
	input  logic [15:0]       index_limit_wdata,
	output logic              item_valid,
	input  logic              item_pop,
	output tskv_pkg::item_t   item
);

	logic [15:0]     limit_q;
	tskv_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	tskv_pkg::item_t new_item;
	logic            push;

	always_comb begin
		new_item.command   = command;
		new_item.key_index = key_index;
		new_item.value     = value;
		new_item.fallback  = fallback;
		new_item.key_bad   = (key_index == 16'd0) || (key_index > limit_q);
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= tskv_pkg::LIMIT_RESET;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (index_limit_we) begin
				limit_q <= index_limit_wdata;
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(item_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

>>> rtl/tskv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tskv_back
// Sequencer over the sector memory: append, backward search, compaction.
// ----------------------------------------------------------------------------
module tskv_back #(
	parameter int SECTOR_WORDS = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_pop,
	input  tskv_pkg::item_t item,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     read_value,
	output logic [1:0]      status
);

	localparam int WPW = $clog2(SECTOR_WORDS + 1);
	localparam int AW  = $clog2(SECTOR_WORDS);
	localparam logic [WPW:0] SW_W = (WPW + 1)'(SECTOR_WORDS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_FLAG = 3'd2;
	localparam logic [2:0] ST_DATA = 3'd3;
	localparam logic [2:0] ST_CW1  = 3'd4;
	localparam logic [2:0] ST_CW2  = 3'd5;
	localparam logic [2:0] ST_CFIN = 3'd6;
	localparam logic [2:0] ST_AP1  = 3'd7;

	logic [31:0] mem [2 ** (AW + 1)];
	logic [31:0] rdata_q;
	logic        rd_en;
	logic [AW:0] rd_addr;
	logic        wr_en;
	logic [AW:0] wr_addr;
	logic [31:0] wr_data;

	logic [2:0]      state_q;
	logic            ap2_q;
	tskv_pkg::item_t cur_q;
	logic [WPW-1:0]  wp_q;
	logic [WPW-1:0]  nwp_q;
	logic [15:0]     hk_q;
	logic            act_q;
	logic            compact_q;
	logic [15:0]     k_q;
	logic [WPW-1:0]  ent_q;
	logic [AW-1:0]   off_q;
	logic [31:0]     got_q;
	logic [31:0]     rv_q;
	logic [1:0]      st_q;
	logic            ov_q;

	logic [AW-1:0]   srch_off;
	logic [15:0]     srch_key;
	logic            wp_full;
	logic            nwp_full;

	assign srch_off = AW'((ent_q - WPW'(1)) << 1);
	assign srch_key = compact_q ? k_q : cur_q.key_index;
	assign wp_full  = ({1'b0, wp_q} + (WPW + 1)'(2)) > SW_W;
	assign nwp_full = ({1'b0, nwp_q} + (WPW + 1)'(2)) > SW_W;

	assign item_pop   = (state_q == ST_IDLE) && !ap2_q && item_valid && !ov_q;
	assign out_valid  = ov_q;
	assign read_value = rv_q;
	assign status     = st_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {act_q, srch_off};
		wr_en   = 1'b0;
		wr_addr = {act_q, AW'(wp_q)};
		wr_data = {tskv_pkg::FLAG_MARK, cur_q.key_index};
		if (ap2_q) begin
			wr_en   = 1'b1;
			wr_addr = {act_q, AW'(wp_q + WPW'(1))};
			wr_data = cur_q.value;
		end else begin
			unique case (state_q)
				ST_SRCH: begin
					rd_en = (ent_q != '0);
				end
				ST_FLAG: begin
					rd_en   = 1'b1;
					rd_addr = {act_q, off_q | AW'(1)};
				end
				ST_CW1: begin
					wr_en   = 1'b1;
					wr_addr = {~act_q, AW'(nwp_q)};
					wr_data = {tskv_pkg::FLAG_MARK, k_q};
				end
				ST_CW2: begin
					wr_en   = 1'b1;
					wr_addr = {~act_q, AW'(nwp_q + WPW'(1))};
					wr_data = got_q;
				end
				ST_AP1: begin
					wr_en = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			cur_q <= item;
		end
		if (state_q == ST_SRCH) begin
			off_q <= srch_off;
		end
		if (state_q == ST_DATA) begin
			got_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ap2_q     <= 1'b0;
			wp_q      <= '0;
			nwp_q     <= '0;
			hk_q      <= '0;
			act_q     <= 1'b0;
			compact_q <= 1'b0;
			k_q       <= '0;
			ent_q     <= '0;
			rv_q      <= '0;
			st_q      <= tskv_pkg::STAT_OK;
			ov_q      <= 1'b0;
		end else begin
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			if (ap2_q) begin
				// second word of the appended entry
				ap2_q <= 1'b0;
				wp_q  <= wp_q + WPW'(2);
				if (cur_q.key_index > hk_q) begin
					hk_q <= cur_q.key_index;
				end
				rv_q <= '0;
				st_q <= tskv_pkg::STAT_OK;
				ov_q <= 1'b1;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (item_pop) begin
							rv_q      <= '0;
							st_q      <= tskv_pkg::STAT_OK;
							compact_q <= 1'b0;
							ent_q     <= wp_q >> 1;
							if (item.command == tskv_pkg::CMD_MOUNT) begin
								// an empty log mounts on sector b
								if (wp_q == '0) begin
									act_q <= 1'b1;
								end
								ov_q <= 1'b1;
							end else if (item.command == tskv_pkg::CMD_WRITE) begin
								if (item.key_bad) begin
									st_q <= tskv_pkg::STAT_RANGE;
									ov_q <= 1'b1;
								end else if (wp_full) begin
									compact_q <= 1'b1;
									k_q       <= 16'd1;
									nwp_q     <= '0;
									state_q   <= (hk_q == '0) ? ST_CFIN : ST_SRCH;
								end else begin
									state_q <= ST_AP1;
								end
							end else if (item.command == tskv_pkg::CMD_READ) begin
								rv_q <= item.fallback;
								if (item.key_bad) begin
									st_q <= tskv_pkg::STAT_RANGE;
									ov_q <= 1'b1;
								end else if (item.key_index > hk_q || wp_q < WPW'(2)) begin
									st_q <= tskv_pkg::STAT_NONE;
									ov_q <= 1'b1;
								end else begin
									state_q <= ST_SRCH;
								end
							end else begin
								ov_q <= 1'b1;
							end
						end
					end
					ST_SRCH, ST_FLAG: begin
						logic miss;
						logic skip;
						miss = 1'b0;
						skip = 1'b0;
						if (state_q == ST_SRCH) begin
							if (ent_q == '0) begin
								miss = 1'b1;
							end else begin
								ent_q   <= ent_q - WPW'(1);
								state_q <= ST_FLAG;
							end
						end else if (rdata_q == tskv_pkg::ERASED) begin
							miss = 1'b1;
						end else if (rdata_q[31:16] != tskv_pkg::FLAG_MARK ||
								rdata_q[15:0] != srch_key) begin
							skip = 1'b1;
						end else begin
							state_q <= ST_DATA;
						end
						if (skip) begin
							state_q <= ST_SRCH;
						end
						if (miss) begin
							if (!compact_q) begin
								st_q    <= tskv_pkg::STAT_NONE;
								ov_q    <= 1'b1;
								state_q <= ST_IDLE;
							end else if (k_q == hk_q) begin
								state_q <= ST_CFIN;
							end else begin
								k_q     <= k_q + 16'd1;
								ent_q   <= wp_q >> 1;
								state_q <= ST_SRCH;
							end
						end
					end
					ST_DATA: begin
						if (!compact_q) begin
							rv_q    <= rdata_q;
							st_q    <= tskv_pkg::STAT_OK;
							ov_q    <= 1'b1;
							state_q <= ST_IDLE;
						end else if (nwp_full) begin
							// copied set overflows: old sector stays active
							st_q    <= tskv_pkg::STAT_FULL;
							ov_q    <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_CW1;
						end
					end
					ST_CW1: begin
						state_q <= ST_CW2;
					end
					ST_CW2: begin
						nwp_q <= nwp_q + WPW'(2);
						if (k_q == hk_q) begin
							state_q <= ST_CFIN;
						end else begin
							k_q     <= k_q + 16'd1;
							ent_q   <= wp_q >> 1;
							state_q <= ST_SRCH;
						end
					end
					ST_CFIN: begin
						if (nwp_full) begin
							st_q    <= tskv_pkg::STAT_FULL;
							ov_q    <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							act_q   <= ~act_q;
							wp_q    <= nwp_q;
							state_q <= ST_AP1;
						end
					end
					ST_AP1: begin
						ap2_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule
